// ----- src/afs_pkg.sv -----
// Shared types, constants and the microcode table for the arm flip sequencer.
// No dependencies; every other file imports this package.
package afs_pkg;

    // Payload of one request and one result
    typedef struct packed {
        logic [11:0] flip_sample;
        logic [11:0] wrist_sample;
        logic        flip_button;
        logic        quick_button;
        logic        abort_button;
        logic        wrist_up_button;
        logic        wrist_down_button;
        logic        flip_left_button;
        logic        flip_right_button;
    } afs_in_t;

    typedef struct packed {
        logic signed [7:0] wrist_drive;
        logic signed [7:0] flip_drive;
        logic [2:0]        sequence_step;
    } afs_out_t;

    // Configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_WRIST_GAIN       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_GAIN        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRIST_LOWER_RATE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRIST_HOLD_POS   = 2'd3;

    typedef struct packed {
        logic [7:0] wrist_gain;
        logic [7:0] flip_gain;
        logic [7:0] wrist_lower_rate;
        logic [6:0] wrist_hold_position;
    } afs_cfg_t;

    localparam logic [7:0] WRIST_GAIN_RST  = 8'd32;
    localparam logic [7:0] FLIP_GAIN_RST   = 8'd32;
    localparam logic [7:0] LOWER_RATE_RST  = 8'd40;
    localparam logic [6:0] HOLD_POS_RST    = 7'd10;

    localparam int TICK_MS_DEFAULT = 10;

    // Position conversion: zero points of the pots and reciprocals.
    // flip  = 7*|x| + floor(|x|*RECIP_FLIP >> 15)        (x*256/36)
    // wrist = 9*|y| + floor(13*|y|*RECIP_WRIST >> 20)    (y*256/27)
    // drop  = floor((p >> 3) * RECIP_DROP >> 20)         (p/1000)
    localparam logic signed [12:0] FLIP_ZERO  = 13'sd4000;
    localparam logic signed [12:0] WRIST_ZERO = 13'sd3200;
    localparam logic [17:0] RECIP_FLIP  = 18'd3641;
    localparam logic [17:0] RECIP_WRIST = 18'd38837;
    localparam logic [17:0] RECIP_DROP  = 18'd8389;
    localparam logic [35:0] DROP_LIMIT  = 36'd61000;

    localparam logic signed [15:0] POS50_Q8        = 16'sd12800;
    localparam logic signed [15:0] POS30_Q8        = 16'sd7680;
    localparam logic signed [15:0] POS5_Q8         = 16'sd1280;
    localparam logic signed [15:0] WRIST_OFFSET_Q8 = 16'sd2560;
    localparam logic signed [16:0] FLIP_FLIPPED_Q8 = 17'sd256;
    localparam logic [6:0]         SEEK_HIGH       = 7'd60;
    localparam logic signed [7:0]  DRIVE_MAX       = 8'sd127;
    localparam logic signed [7:0]  DRIVE_MIN       = -8'sd127;

    // Sequence step codes
    localparam logic [2:0] STEP_IDLE    = 3'd0;
    localparam logic [2:0] STEP_RELEASE = 3'd1;
    localparam logic [2:0] STEP_RAISE   = 3'd2;
    localparam logic [2:0] STEP_READY   = 3'd3;
    localparam logic [2:0] STEP_LOWER   = 3'd4;
    localparam logic [2:0] STEP_QUICK   = 3'd5;
    localparam logic [2:0] STEP_SETTLE  = 3'd6;
    localparam logic [2:0] STEP_UNUSED  = 3'd7;

    // Control word fields
    typedef enum logic [2:0] {
        A_NONE, A_ABS_FX, A_Y13, A_RATE, A_TICKS, A_P3, A_WERR, A_FERR
    } a_sel_t;

    typedef enum logic [2:0] {
        B_NONE, B_K_FLIP, B_K_WRIST, B_TICK, B_PROD, B_K_DROP, B_WGAIN, B_FGAIN
    } b_sel_t;

    typedef enum logic [3:0] {
        WB_NONE, WB_CAPTURE, WB_FLIP_POS, WB_WRIST_POS, WB_DROP_BIG, WB_DROP,
        WB_SEQ, WB_WDRIVE, WB_FDRIVE, WB_FINISH
    } wb_t;

    typedef enum logic [1:0] {
        JC_NEXT, JC_WAIT_REQ, JC_WAIT_OUT
    } jc_t;

    typedef logic [3:0] pc_t;
    localparam pc_t PC_FETCH = 4'd0;

    typedef struct packed {
        a_sel_t a_sel;
        b_sel_t b_sel;
        wb_t    wb;
        jc_t    jc;
        pc_t    target;
    } uword_t;

    typedef struct packed {
        logic req_valid;
        logic out_busy;
    } afs_stat_t;

    // Microprogram: the multiplier result is registered in the product register,
    // so each write-back consumes the previous step's product.
    function automatic uword_t ucode_rom(input pc_t pc);
        uword_t w;
        case (pc)
            4'd0:    w = '{A_NONE,   B_NONE,    WB_CAPTURE,   JC_WAIT_REQ, PC_FETCH};
            4'd1:    w = '{A_ABS_FX, B_K_FLIP,  WB_NONE,      JC_NEXT,     PC_FETCH};
            4'd2:    w = '{A_Y13,    B_K_WRIST, WB_FLIP_POS,  JC_NEXT,     PC_FETCH};
            4'd3:    w = '{A_RATE,   B_TICK,    WB_WRIST_POS, JC_NEXT,     PC_FETCH};
            4'd4:    w = '{A_TICKS,  B_PROD,    WB_NONE,      JC_NEXT,     PC_FETCH};
            4'd5:    w = '{A_P3,     B_K_DROP,  WB_DROP_BIG,  JC_NEXT,     PC_FETCH};
            4'd6:    w = '{A_NONE,   B_NONE,    WB_DROP,      JC_NEXT,     PC_FETCH};
            4'd7:    w = '{A_NONE,   B_NONE,    WB_SEQ,       JC_NEXT,     PC_FETCH};
            4'd8:    w = '{A_WERR,   B_WGAIN,   WB_NONE,      JC_NEXT,     PC_FETCH};
            4'd9:    w = '{A_FERR,   B_FGAIN,   WB_WDRIVE,    JC_NEXT,     PC_FETCH};
            4'd10:   w = '{A_NONE,   B_NONE,    WB_FDRIVE,    JC_NEXT,     PC_FETCH};
            4'd11:   w = '{A_NONE,   B_NONE,    WB_FINISH,    JC_WAIT_OUT, PC_FETCH};
            default: w = '{A_NONE,   B_NONE,    WB_NONE,      JC_WAIT_OUT, PC_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ----- src/afs_ctrl.sv -----
// Microcode sequencer: step counter, control word lookup and conditional jumps.
// Depends on afs_pkg.
module afs_ctrl
    import afs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  afs_stat_t stat,
    output uword_t    uword,
    output logic      step_go,
    output logic      fetch_ready
);

    pc_t pc_reg, pc_next;

    assign uword       = ucode_rom(pc_reg);
    assign fetch_ready = (pc_reg == PC_FETCH);

    always_comb begin
        step_go = 1'b1;
        pc_next = pc_reg + 4'd1;
        case (uword.jc)
            JC_NEXT: begin
                step_go = 1'b1;
                pc_next = pc_reg + 4'd1;
            end
            JC_WAIT_REQ: begin
                // hold until a request arrives
                step_go = stat.req_valid;
                pc_next = stat.req_valid ? pc_reg + 4'd1 : pc_reg;
            end
            JC_WAIT_OUT: begin
                // hold while the previous result is still waiting
                step_go = ~stat.out_busy;
                pc_next = stat.out_busy ? pc_reg : uword.target;
            end
            default: begin
                step_go = 1'b0;
                pc_next = PC_FETCH;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- src/afs_datapath.sv -----
// Datapath: shared multiplier, position and drive registers, flip sequence
// state and the result register. Depends on afs_pkg.
module afs_datapath
    import afs_pkg::*;
#(
    parameter int unsigned TICK_MS = TICK_MS_DEFAULT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  afs_cfg_t cfg,
    input  uword_t   uword,
    input  logic     step_go,
    input  afs_in_t  s_data,
    output logic     out_busy,
    output logic     m_valid,
    input  logic     m_ready,
    output afs_out_t m_data
);

    // Sequence state (reset)
    logic [2:0]  step_reg, step_next;
    logic        quick_reg, quick_next;
    logic        won_reg, won_next;
    logic [6:0]  wt_reg, wt_next;
    logic        fon_reg, fon_next;
    logic [15:0] ticks_reg, ticks_next;
    logic        m_valid_reg, m_valid_next;

    // Working registers (no reset)
    afs_in_t            in_reg, in_next;
    logic signed [35:0] prod_reg;
    logic signed [15:0] flip_q8_reg, flip_q8_next;
    logic signed [15:0] wrist_q8_reg, wrist_q8_next;
    logic               drop_big_reg, drop_big_next;
    logic [5:0]         drop_reg, drop_next;
    logic signed [7:0]  wdrive_reg, wdrive_next;
    logic signed [7:0]  fdrive_reg, fdrive_next;
    afs_out_t           out_reg, out_next;

    logic signed [12:0] fx, wy;
    logic [11:0]        abs_fx, abs_wy;
    logic [15:0]        y13;
    logic [14:0]        flip_mag, wrist_mag;
    logic signed [15:0] flip_pos, wrist_raw, wrist_pos, hold_q8;
    logic signed [16:0] err_w, err_f;
    logic signed [17:0] mul_a, mul_b;

    function automatic logic signed [7:0] drive_sat(input logic signed [35:0] p);
        logic signed [25:0] v;
        logic signed [25:0] adj;
        logic signed [13:0] q;
        v   = signed'(p[25:0]);
        // divide by 4096 toward zero
        adj = v[25] ? v + 26'sd4095 : v;
        q   = signed'(adj[25:12]);
        if (q > 14'sd127) begin
            return DRIVE_MAX;
        end else if (q < -14'sd127) begin
            return DRIVE_MIN;
        end else begin
            return q[7:0];
        end
    endfunction

    // Position arithmetic from the captured request
    assign fx     = FLIP_ZERO - signed'({1'b0, in_reg.flip_sample});
    assign wy     = WRIST_ZERO - signed'({1'b0, in_reg.wrist_sample});
    assign abs_fx = fx[12] ? 12'(-fx) : fx[11:0];
    assign abs_wy = wy[12] ? 12'(-wy) : wy[11:0];
    assign y13    = 16'({abs_wy, 3'b000}) + 16'({abs_wy, 2'b00}) + 16'(abs_wy);

    assign flip_mag  = 15'({abs_fx, 3'b000}) - 15'(abs_fx) + 15'(prod_reg[23:15]);
    assign wrist_mag = 15'({abs_wy, 3'b000}) + 15'(abs_wy) + 15'(prod_reg[30:20]);
    assign flip_pos  = fx[12] ? -signed'({1'b0, flip_mag}) : signed'({1'b0, flip_mag});
    assign wrist_raw = wy[12] ? -signed'({1'b0, wrist_mag}) : signed'({1'b0, wrist_mag});
    assign wrist_pos = (flip_q8_reg < POS50_Q8) ? wrist_raw - WRIST_OFFSET_Q8 : wrist_raw;
    assign hold_q8   = signed'({1'b0, cfg.wrist_hold_position, 8'b0});

    assign err_w = 17'(wrist_q8_reg) - signed'({2'b00, wt_reg, 8'b0});
    assign err_f = 17'(flip_q8_reg) - FLIP_FLIPPED_Q8;

    always_comb begin
        case (uword.a_sel)
            A_ABS_FX: mul_a = signed'({6'b0, abs_fx});
            A_Y13:    mul_a = signed'({2'b0, y13});
            A_RATE:   mul_a = signed'({10'b0, cfg.wrist_lower_rate});
            A_TICKS:  mul_a = signed'({2'b0, ticks_reg});
            A_P3:     mul_a = signed'({5'b0, prod_reg[15:3]});
            A_WERR:   mul_a = {err_w[16], err_w};
            A_FERR:   mul_a = {err_f[16], err_f};
            default:  mul_a = '0;
        endcase
        case (uword.b_sel)
            B_K_FLIP:  mul_b = signed'(RECIP_FLIP);
            B_K_WRIST: mul_b = signed'(RECIP_WRIST);
            B_TICK:    mul_b = signed'(18'(TICK_MS));
            B_PROD:    mul_b = signed'({3'b0, prod_reg[14:0]});
            B_K_DROP:  mul_b = signed'(RECIP_DROP);
            B_WGAIN:   mul_b = signed'({10'b0, cfg.wrist_gain});
            B_FGAIN:   mul_b = signed'({10'b0, cfg.flip_gain});
            default:   mul_b = '0;
        endcase
    end

    always_comb begin
        logic [2:0] s;
        logic       q;
        logic       won;
        logic [6:0] wt;
        logic       fon;
        logic       clr;
        logic       big;
        logic [5:0] drop;
        logic       b_start;
        logic signed [7:0] wd;
        logic signed [7:0] fd;

        step_next     = step_reg;
        quick_next    = quick_reg;
        won_next      = won_reg;
        wt_next       = wt_reg;
        fon_next      = fon_reg;
        ticks_next    = ticks_reg;
        m_valid_next  = m_valid_reg & ~m_ready;
        in_next       = in_reg;
        flip_q8_next  = flip_q8_reg;
        wrist_q8_next = wrist_q8_reg;
        drop_big_next = drop_big_reg;
        drop_next     = drop_reg;
        wdrive_next   = wdrive_reg;
        fdrive_next   = fdrive_reg;
        out_next      = out_reg;

        s       = (step_reg == STEP_UNUSED) ? STEP_IDLE : step_reg;
        q       = quick_reg;
        won     = won_reg;
        wt      = wt_reg;
        fon     = fon_reg;
        clr     = 1'b0;
        big     = drop_big_reg;
        drop    = drop_reg;
        b_start = in_reg.flip_button | in_reg.quick_button;
        wd      = wdrive_reg;
        fd      = fdrive_reg;

        if (step_go) begin
            case (uword.wb)
                WB_CAPTURE:   in_next       = s_data;
                WB_FLIP_POS:  flip_q8_next  = flip_pos;
                WB_WRIST_POS: wrist_q8_next = wrist_pos;
                WB_DROP_BIG:  drop_big_next = (prod_reg >= signed'(DROP_LIMIT));
                WB_DROP:      drop_next     = prod_reg[25:20];
                WB_SEQ: begin
                    // steps fall through in ascending order within one tick
                    if (in_reg.flip_button && s == STEP_IDLE) begin
                        s = STEP_RELEASE;
                        q = 1'b0;
                    end
                    if (in_reg.quick_button && s == STEP_IDLE) begin
                        s = STEP_RELEASE;
                        q = 1'b1;
                    end
                    if (s == STEP_RELEASE && !in_reg.flip_button) begin
                        s = STEP_RAISE;
                    end
                    if (s == STEP_RAISE) begin
                        won = 1'b1;
                        wt  = SEEK_HIGH;
                        if (wrist_q8_reg > POS50_Q8) begin
                            s = STEP_READY;
                        end
                    end
                    if (s == STEP_READY) begin
                        won = 1'b1;
                        wt  = SEEK_HIGH;
                        fon = 1'b1;
                        if (flip_q8_reg < POS30_Q8 && b_start) begin
                            s   = q ? STEP_QUICK : STEP_LOWER;
                            clr = 1'b1;
                        end
                    end
                    if (s == STEP_LOWER) begin
                        // a fresh lowering starts with zero elapsed time
                        if (clr) begin
                            big  = 1'b0;
                            drop = '0;
                        end
                        won = ~big;
                        if (!big) begin
                            wt = SEEK_HIGH - 7'(drop);
                        end
                        fon = 1'b1;
                        if (wrist_q8_reg < hold_q8) begin
                            s = STEP_SETTLE;
                        end
                    end
                    if (s == STEP_QUICK) begin
                        won = 1'b1;
                        wt  = SEEK_HIGH;
                        fon = 1'b1;
                        if (flip_q8_reg < POS5_Q8) begin
                            s = STEP_SETTLE;
                        end
                    end
                    if (s == STEP_SETTLE) begin
                        fon = 1'b1;
                        won = 1'b1;
                        wt  = cfg.wrist_hold_position;
                        if (wrist_q8_reg < hold_q8) begin
                            s   = STEP_IDLE;
                            fon = 1'b0;
                        end
                    end
                    step_next  = s;
                    quick_next = q;
                    won_next   = won;
                    wt_next    = wt;
                    fon_next   = fon;
                    if (clr) begin
                        ticks_next = '0;
                    end
                end
                WB_WDRIVE: wdrive_next = won_reg ? drive_sat(prod_reg) : 8'sd0;
                WB_FDRIVE: fdrive_next = fon_reg ? drive_sat(prod_reg) : 8'sd0;
                WB_FINISH: begin
                    s   = step_reg;
                    won = won_reg;
                    fon = fon_reg;
                    if (in_reg.abort_button) begin
                        won = 1'b0;
                        fon = 1'b0;
                        s   = STEP_IDLE;
                    end
                    if (in_reg.wrist_up_button) begin
                        wd  = DRIVE_MAX;
                        won = 1'b0;
                    end
                    if (in_reg.wrist_down_button) begin
                        wd  = DRIVE_MIN;
                        won = 1'b0;
                    end
                    if (in_reg.flip_left_button) begin
                        fd  = DRIVE_MAX;
                        fon = 1'b0;
                    end
                    if (in_reg.flip_right_button) begin
                        fd  = DRIVE_MIN;
                        fon = 1'b0;
                    end
                    step_next = s;
                    won_next  = won;
                    fon_next  = fon;
                    if (ticks_reg != 16'hFFFF) begin
                        ticks_next = ticks_reg + 16'd1;
                    end
                    out_next     = '{wrist_drive: wd, flip_drive: fd, sequence_step: s};
                    m_valid_next = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= STEP_IDLE;
            quick_reg   <= 1'b0;
            won_reg     <= 1'b0;
            wt_reg      <= '0;
            fon_reg     <= 1'b0;
            ticks_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            quick_reg   <= quick_next;
            won_reg     <= won_next;
            wt_reg      <= wt_next;
            fon_reg     <= fon_next;
            ticks_reg   <= ticks_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg       <= in_next;
        prod_reg     <= mul_a * mul_b;
        flip_q8_reg  <= flip_q8_next;
        wrist_q8_reg <= wrist_q8_next;
        drop_big_reg <= drop_big_next;
        drop_reg     <= drop_next;
        wdrive_reg   <= wdrive_next;
        fdrive_reg   <= fdrive_next;
        out_reg      <= out_next;
    end

    assign out_busy = m_valid_reg & ~m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

endmodule

// ----- src/arm_flip_sequencer.sv -----
// Arm flip sequencer top level: configuration registers, microcode
// sequencer and datapath. Depends on afs_pkg, afs_ctrl, afs_datapath.
// Requests: one at a time, as the 12-word microprogram shares one 18x18
// multiplier; the next request is taken once the result has moved into the
// output register, even while it waits for m_ready, and the program stalls
// before that move while an earlier result still waits.
// Reset: aresetn, synchronous active low; clears the sequence, targets, tick
// counter and output valid, and restores the register defaults.
module arm_flip_sequencer
    import afs_pkg::*;
#(
    parameter int unsigned TICK_MS = TICK_MS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  afs_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output afs_out_t              m_data
);

    afs_cfg_t  cfg_reg, cfg_next;
    afs_stat_t stat;
    uword_t    uword;
    logic      step_go;
    logic      out_busy;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WRIST_GAIN:       cfg_next.wrist_gain          = cfg_wr_data;
                CFG_FLIP_GAIN:        cfg_next.flip_gain           = cfg_wr_data;
                CFG_WRIST_LOWER_RATE: cfg_next.wrist_lower_rate    = cfg_wr_data;
                CFG_WRIST_HOLD_POS:   cfg_next.wrist_hold_position = cfg_wr_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{wrist_gain:          WRIST_GAIN_RST,
                         flip_gain:           FLIP_GAIN_RST,
                         wrist_lower_rate:    LOWER_RATE_RST,
                         wrist_hold_position: HOLD_POS_RST};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign stat = '{req_valid: s_valid, out_busy: out_busy};

    afs_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .stat        (stat),
        .uword       (uword),
        .step_go     (step_go),
        .fetch_ready (s_ready)
    );

    afs_datapath #(
        .TICK_MS (TICK_MS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .uword    (uword),
        .step_go  (step_go),
        .s_data   (s_data),
        .out_busy (out_busy),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ----- bench/afs_tick_checker.sv -----
`timescale 1ns / 100ps
// Checker for the arm flip sequencer: tracks register writes and accepted
// requests, predicts each tick's drives and step, and compares the results.
// Depends on afs_pkg only.
module afs_tick_checker
    import afs_pkg::*;
#(
    parameter int TICK_MS = TICK_MS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  afs_in_t               s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  afs_out_t              m_data,
    output int                    fail_count,
    output int                    outstanding
);

    localparam int FLIP_ZERO_CNT  = 4000;
    localparam int WRIST_ZERO_CNT = 3200;
    localparam int FLIP_CNT_DIV   = 36;
    localparam int WRIST_CNT_DIV  = 27;
    localparam int Q8             = 256;
    localparam int SEEK_POS       = 60;
    localparam int FLIPPED_POS    = 1;
    localparam int DRIVE_LIM      = 127;

    logic [7:0]  wrist_gain_r;
    logic [7:0]  flip_gain_r;
    logic [7:0]  lower_rate_r;
    logic [6:0]  hold_pos_r;

    logic [2:0]  step_r;
    bit          quick_r;
    bit          wrist_on;
    bit          flip_on;
    logic [15:0] wrist_tgt;
    logic [15:0] flip_tgt;
    logic [15:0] lower_ticks_r;

    afs_out_t    pending_drives[$];

    function automatic void aim_wrist(input int pos);
        wrist_on  = 1'b1;
        wrist_tgt = pos[15:0];
    endfunction

    function automatic void aim_flip(input int pos);
        flip_on  = 1'b1;
        flip_tgt = pos[15:0];
    endfunction

    function automatic int drive_of(input int pos_q8, input logic [15:0] tgt,
                                    input logic [7:0] gain);
        longint err;
        longint v;
        err = longint'(pos_q8) - longint'(tgt) * Q8;
        v = (err * longint'(gain)) / 4096;
        if (v > DRIVE_LIM) v = DRIVE_LIM;
        if (v < -DRIVE_LIM) v = -DRIVE_LIM;
        return int'(v);
    endfunction

    // One control tick: advance the sequence and work out both drives.
    function automatic afs_out_t tick_drives(input afs_in_t r);
        int       flip_q8;
        int       wrist_q8;
        int       hold_q8;
        int       wdrive;
        int       fdrive;
        longint   drop;
        afs_out_t res;
        hold_q8 = int'(hold_pos_r) * Q8;
        wdrive = 0;
        fdrive = 0;
        if (step_r == STEP_UNUSED) step_r = STEP_IDLE;

        flip_q8  = ((FLIP_ZERO_CNT - int'(r.flip_sample)) * Q8) / FLIP_CNT_DIV;
        wrist_q8 = ((WRIST_ZERO_CNT - int'(r.wrist_sample)) * Q8) / WRIST_CNT_DIV;
        if (flip_q8 < 50 * Q8) wrist_q8 -= 10 * Q8;

        if (r.flip_button && step_r == STEP_IDLE) begin
            step_r  = STEP_RELEASE;
            quick_r = 1'b0;
        end
        if (r.quick_button && step_r == STEP_IDLE) begin
            step_r  = STEP_RELEASE;
            quick_r = 1'b1;
        end

        // Steps fall through in ascending order within one tick
        if (step_r == STEP_RELEASE && !r.flip_button) step_r = STEP_RAISE;
        if (step_r == STEP_RAISE) begin
            aim_wrist(SEEK_POS);
            if (wrist_q8 > 50 * Q8) step_r = STEP_READY;
        end
        if (step_r == STEP_READY) begin
            aim_wrist(SEEK_POS);
            aim_flip(FLIPPED_POS);
            if (flip_q8 < 30 * Q8 && (r.flip_button || r.quick_button)) begin
                step_r = quick_r ? STEP_QUICK : STEP_LOWER;
                lower_ticks_r = '0;
            end
        end
        if (step_r == STEP_LOWER) begin
            drop = (longint'(lower_rate_r) * longint'(lower_ticks_r) * TICK_MS) / 1000;
            if (drop <= SEEK_POS) aim_wrist(SEEK_POS - int'(drop));
            else wrist_on = 1'b0;
            aim_flip(FLIPPED_POS);
            if (wrist_q8 < hold_q8) step_r = STEP_SETTLE;
        end
        if (step_r == STEP_QUICK) begin
            aim_wrist(SEEK_POS);
            aim_flip(FLIPPED_POS);
            if (flip_q8 < 5 * Q8) step_r = STEP_SETTLE;
        end
        if (step_r == STEP_SETTLE) begin
            aim_flip(FLIPPED_POS);
            aim_wrist(int'(hold_pos_r));
            if (wrist_q8 < hold_q8) begin
                step_r  = STEP_IDLE;
                flip_on = 1'b0;
            end
        end

        if (wrist_on) wdrive = drive_of(wrist_q8, wrist_tgt, wrist_gain_r);
        if (flip_on) fdrive = drive_of(flip_q8, flip_tgt, flip_gain_r);

        // Abort clears state only after this tick's drives are formed
        if (r.abort_button) begin
            wrist_on = 1'b0;
            flip_on  = 1'b0;
            step_r   = STEP_IDLE;
        end
        if (r.wrist_up_button) begin
            wdrive = DRIVE_LIM;
            wrist_on = 1'b0;
        end
        if (r.wrist_down_button) begin
            wdrive = -DRIVE_LIM;
            wrist_on = 1'b0;
        end
        if (r.flip_left_button) begin
            fdrive = DRIVE_LIM;
            flip_on = 1'b0;
        end
        if (r.flip_right_button) begin
            fdrive = -DRIVE_LIM;
            flip_on = 1'b0;
        end

        if (lower_ticks_r != 16'hFFFF) lower_ticks_r++;

        res.wrist_drive   = wdrive[7:0];
        res.flip_drive    = fdrive[7:0];
        res.sequence_step = step_r;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name,
                     $signed(want), $signed(got));
        end
    endtask

    always @(posedge aclk) begin
        afs_out_t want;
        if (!aresetn) begin
            wrist_gain_r  = WRIST_GAIN_RST;
            flip_gain_r   = FLIP_GAIN_RST;
            lower_rate_r  = LOWER_RATE_RST;
            hold_pos_r    = HOLD_POS_RST;
            step_r        = STEP_IDLE;
            quick_r       = 1'b0;
            wrist_on      = 1'b0;
            flip_on       = 1'b0;
            wrist_tgt     = '0;
            flip_tgt      = '0;
            lower_ticks_r = '0;
            pending_drives.delete();
            fail_count    = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_drives.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with none expected: %0d %0d %0d", $time,
                             m_data.wrist_drive, m_data.flip_drive,
                             m_data.sequence_step);
                end else begin
                    want = pending_drives.pop_front();
                    check_field("wrist_drive", want.wrist_drive, m_data.wrist_drive);
                    check_field("flip_drive", want.flip_drive, m_data.flip_drive);
                    check_field("sequence_step", {5'd0, want.sequence_step},
                                {5'd0, m_data.sequence_step});
                end
            end
            if (s_valid && s_ready) pending_drives.push_back(tick_drives(s_data));
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_WRIST_GAIN:       wrist_gain_r = cfg_wr_data;
                    CFG_FLIP_GAIN:        flip_gain_r  = cfg_wr_data;
                    CFG_WRIST_LOWER_RATE: lower_rate_r = cfg_wr_data;
                    CFG_WRIST_HOLD_POS:   hold_pos_r   = cfg_wr_data[6:0];
                    default: ;
                endcase
            end
        end
        outstanding = pending_drives.size();
    end

endmodule

// ----- bench/tb_arm_flip_sequencer.sv -----
`timescale 1ns / 100ps
// Top of the arm flip sequencer bench: clock, reset, request and result
// traffic, register writes and the verdict. Depends on afs_pkg,
// arm_flip_sequencer and afs_tick_checker.
module tb_arm_flip_sequencer
    import afs_pkg::*;
();

    localparam int TICK_MS        = TICK_MS_DEFAULT;
    localparam int PHASE_ITEMS    = 100;
    localparam int HOLDOFF_CYCLES = 300;

    // Button field order: flip, quick, abort, wrist up/down, flip left/right
    localparam logic [6:0] BTN_NONE   = 7'b0000000;
    localparam logic [6:0] BTN_FLIP   = 7'b1000000;
    localparam logic [6:0] BTN_QUICK  = 7'b0100000;
    localparam logic [6:0] BTN_ABORT  = 7'b0010000;
    localparam logic [6:0] BTN_WUP    = 7'b0001000;
    localparam logic [6:0] BTN_WDOWN  = 7'b0000100;
    localparam logic [6:0] BTN_FLEFT  = 7'b0000010;
    localparam logic [6:0] BTN_FRIGHT = 7'b0000001;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    afs_in_t               s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    afs_out_t              m_data;

    int fail_count;
    int outstanding;
    int sent       = 0;
    int gap_pct    = 0;
    int stall_pct  = 0;
    bit holdoff_go = 1'b0;

    arm_flip_sequencer #(
        .TICK_MS(TICK_MS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    afs_tick_checker #(
        .TICK_MS(TICK_MS)
    ) i_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("arm_flip_sequencer test failed");
        $finish;
    end

    // Result side: random stalls plus one long hold-off
    initial begin
        int  holdoff_left;
        bit  holdoff_seen;
        holdoff_left = 0;
        holdoff_seen = 1'b0;
        forever begin
            @(negedge aclk);
            if (holdoff_go && !holdoff_seen) begin
                holdoff_seen = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_ready = 1'b0;
            end else begin
                m_ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic afs_in_t pack_tick(input logic [11:0] fs, input logic [11:0] ws,
                                          input logic [6:0] btn);
        return afs_in_t'({fs, ws, btn});
    endfunction

    // Request that pushes the current step forward, or holds it, with noise
    function automatic afs_in_t shaped_tick(input logic [2:0] phase, input bit advance,
                                            input bit quick_run);
        afs_in_t r;
        r = pack_tick(12'($urandom_range(4095)), 12'($urandom_range(4095)), BTN_NONE);
        case (phase)
            STEP_IDLE: begin
                if (quick_run) begin
                    r.quick_button = 1'b1;
                end else begin
                    r.flip_button  = 1'b1;
                    r.quick_button = ($urandom_range(3) == 0);
                end
            end
            STEP_RELEASE: r.flip_button = !advance;
            STEP_RAISE: begin
                r.wrist_sample = advance ? 12'($urandom_range(1500))
                                         : 12'($urandom_range(4095, 1900));
            end
            STEP_READY: begin
                if (advance) begin
                    r.flip_sample  = 12'($urandom_range(4095, 2930));
                    r.flip_button  = 1'($urandom_range(1));
                    r.quick_button = !r.flip_button || $urandom_range(1);
                end else if ($urandom_range(1)) begin
                    r.flip_sample = 12'($urandom_range(2900));
                    r.flip_button = 1'($urandom_range(1));
                end
            end
            STEP_QUICK: begin
                r.flip_sample = advance ? 12'($urandom_range(4095, 3830))
                                        : 12'($urandom_range(3800));
            end
            default: begin
                r.wrist_sample = advance ? 12'($urandom_range(4095, 3300))
                                         : 12'($urandom_range(2500));
            end
        endcase
        if ($urandom_range(99) < 2) r.abort_button = 1'b1;
        if ($urandom_range(99) < 4) r[3:0] = 4'($urandom);
        return r;
    endfunction

    task automatic send(input afs_in_t req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < gap_pct) gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = req;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic idle_sender();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = val;
    endtask

    task automatic apply_config(input logic [7:0] wgain, input logic [7:0] fgain,
                                input logic [7:0] rate, input logic [7:0] hold);
        write_reg(CFG_WRIST_GAIN, wgain);
        write_reg(CFG_FLIP_GAIN, fgain);
        write_reg(CFG_WRIST_LOWER_RATE, rate);
        write_reg(CFG_WRIST_HOLD_POS, hold);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Walk one auto-flip from start to finish, lingering up to three ticks per step (25 to 45 in a long lowering)
    task automatic run_flip(input bit quick_run, input bit long_lower);
        int waits;
        send(shaped_tick(STEP_IDLE, 1'b1, quick_run));
        for (int k = int'(STEP_RELEASE); k <= int'(STEP_SETTLE); k++) begin
            if (quick_run ? (k == int'(STEP_LOWER)) : (k >= int'(STEP_QUICK))) continue;
            if (k == int'(STEP_LOWER) && long_lower) waits = $urandom_range(45, 25);
            else waits = $urandom_range(3);
            repeat (waits) send(shaped_tick(3'(k), 1'b0, quick_run));
            send(shaped_tick(3'(k), 1'b1, quick_run));
        end
    endtask

    initial begin
        int base;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed ticks on the reset settings
        send(pack_tick(12'd0, 12'd0, BTN_NONE));
        send(pack_tick(12'd4095, 12'd4095, BTN_NONE));
        send(pack_tick(12'd2000, 12'd2000, BTN_FLIP | BTN_QUICK));
        send(pack_tick(12'd2000, 12'd2000, BTN_FLIP));
        send(pack_tick(12'd0, 12'd0, BTN_NONE));
        send(pack_tick(12'd4095, 12'd0, BTN_QUICK));
        send(pack_tick(12'd4095, 12'd1600, BTN_NONE));
        send(pack_tick(12'd3000, 12'd1600, BTN_ABORT));
        send(pack_tick(12'd0, 12'd4095, BTN_QUICK));
        send(pack_tick(12'd0, 12'd0, BTN_NONE));
        send(pack_tick(12'd4095, 12'd0, BTN_FLIP));
        send(pack_tick(12'd4095, 12'd4095, BTN_NONE));
        send(pack_tick(12'd1234, 12'd3210, BTN_WUP | BTN_WDOWN | BTN_FLEFT | BTN_FRIGHT));
        send(pack_tick(12'd3210, 12'd1234, BTN_WUP | BTN_FLEFT));
        send(pack_tick(12'd4095, 12'd4095, 7'h7F));
        send(pack_tick(12'd0, 12'd4095, BTN_FRIGHT | BTN_WDOWN));
        send(pack_tick(12'd2200, 12'd1850, BTN_QUICK));
        send(pack_tick(12'd2920, 12'd1850, BTN_FLIP));

        for (int p = 0; p < 4; p++) begin
            // Drain before touching the registers
            idle_sender();
            wait (outstanding == 0);
            case (p)
                0: begin
                    gap_pct = 0;
                    stall_pct = 0;
                    apply_config(8'd255, 8'd255, 8'd255, 8'd0);
                end
                1: begin
                    gap_pct = 46;
                    stall_pct = 0;
                    apply_config(8'd0, 8'd0, 8'd0, 8'hFF);
                end
                2: begin
                    gap_pct = 0;
                    stall_pct = 46;
                    apply_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                                 8'($urandom_range(255)), 8'($urandom_range(100)));
                end
                default: begin
                    gap_pct = 13;
                    stall_pct = 13;
                    apply_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                                 8'($urandom_range(255)), 8'($urandom_range(255)));
                end
            endcase
            base = sent;
            if (p == 0) run_flip(1'b0, 1'b1);
            if (p == 2) holdoff_go = 1'b1;
            while (sent - base < PHASE_ITEMS) begin
                if ($urandom_range(99) < 80) begin
                    run_flip(1'($urandom_range(1)), $urandom_range(5) == 0);
                end else begin
                    send(afs_in_t'(31'($urandom)));
                end
            end
        end

        idle_sender();
        wait (outstanding == 0);
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("arm_flip_sequencer test passed");
        end else begin
            $display("arm_flip_sequencer test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/afs_pkg.sv
src/afs_ctrl.sv
src/afs_datapath.sv
src/arm_flip_sequencer.sv
bench/afs_tick_checker.sv
bench/tb_arm_flip_sequencer.sv
